### sv/ple_pkg.sv
`default_nettype none

package ple_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int REQ_W  = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;

    typedef logic [REQ_W-1:0]  req_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic signed [VAL_W-1:0] value_t;

    localparam req_t REQ_INS_FRONT = 3'd0;
    localparam req_t REQ_INS_REAR  = 3'd1;
    localparam req_t REQ_INS_AT    = 3'd2;
    localparam req_t REQ_DEL_FRONT = 3'd3;
    localparam req_t REQ_DEL_REAR  = 3'd4;
    localparam req_t REQ_DEL_AT    = 3'd5;
    localparam req_t REQ_READ_ALL  = 3'd6;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

endpackage

`default_nettype wire

### sv/ple_ram.sv
`default_nettype none

module ple_ram #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [IW-1:0]       waddr,
    input  wire ple_pkg::value_t     wdata,
    input  wire logic                re,
    input  wire logic [IW-1:0]       raddr,
    output      ple_pkg::value_t     rdata
);
    import ple_pkg::*;

    value_t mem [DEPTH];
    value_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/positional_list_engine.sv
`default_nettype none

// Positional list engine: ordered list of up to DEPTH signed 32-bit values.
// Command channel: a transaction is taken on a clock edge with start high and
// busy low; req_type, value and position are sampled then. busy falls in the
// cycle the final result is presented, so the next transaction can be taken then.
// Result channel: strobe is high for one cycle per result with status,
// entry_value and last; the receiver cannot stall and must take every result.
// Updates give one result. Read-all gives one result per stored entry, front
// first, one per cycle, last marking the final one; an empty list gives one
// empty-status result.
// Updates: an insert moves count - position entries up a place before it
// writes the new value, and a delete moves count - position - 1 entries
// down a place; errors and the unused code give their result from the
// decide state without touching the list.
// Read-all: after the first result, one result follows per cycle.
// The list storage is a single-port-read, single-port-write RAM; each entry
// moved takes a read state and then a write state, which sets the update time.
// Reset clears the entry count and the sequencer; RAM contents are not cleared.
module positional_list_engine #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output      logic                        busy,
    input  wire logic [ple_pkg::REQ_W-1:0]   req_type,
    input  wire logic signed [ple_pkg::VAL_W-1:0] value,
    input  wire logic [ple_pkg::POS_W-1:0]   position,
    output      logic                        strobe,
    output      logic [ple_pkg::STAT_W-1:0]  status,
    output      logic signed [ple_pkg::VAL_W-1:0] entry_value,
    output      logic                        last
);
    import ple_pkg::*;

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_UP_RD  = 3'd2;
    localparam logic [2:0] S_UP_WR  = 3'd3;
    localparam logic [2:0] S_INS_WR = 3'd4;
    localparam logic [2:0] S_DN_RD  = 3'd5;
    localparam logic [2:0] S_DN_WR  = 3'd6;
    localparam logic [2:0] S_RO     = 3'd7;

    logic [2:0]       state_reg,  state_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic [CW-1:0]    idx_reg,    idx_next;
    logic [CW-1:0]    tgt_reg,    tgt_next;
    req_t             req_reg,    req_next;
    value_t           val_reg,    val_next;
    logic [POS_W-1:0] pos_reg,    pos_next;

    logic             strobe_reg, strobe_next;
    status_t          status_reg, status_next;
    value_t           evalue_reg, evalue_next;
    logic             last_reg,   last_next;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    value_t           ram_wdata;
    logic             ram_re;
    logic [IW-1:0]    ram_raddr;
    value_t           ram_rdata;

    logic [CMPW-1:0]  cnt_ext;
    logic [CMPW-1:0]  pos_eff;
    logic [CW:0]      idx_p1;
    logic [CW:0]      idx_p2;
    logic [CW-1:0]    idx_m1;

    ple_ram #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cnt_ext = CMPW'(count_reg);
    assign idx_p1  = {1'b0, idx_reg} + (CW+1)'(1);
    assign idx_p2  = {1'b0, idx_reg} + (CW+1)'(2);
    assign idx_m1  = idx_reg - CW'(1);

    always_comb
    begin
        unique case (req_reg)
            REQ_INS_FRONT: pos_eff = '0;
            REQ_INS_REAR:  pos_eff = cnt_ext;
            REQ_INS_AT:    pos_eff = CMPW'(pos_reg);
            REQ_DEL_FRONT: pos_eff = '0;
            REQ_DEL_REAR:  pos_eff = cnt_ext - CMPW'(1);
            REQ_DEL_AT:    pos_eff = CMPW'(pos_reg);
            default:       pos_eff = '0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        tgt_next    = tgt_reg;
        req_next    = req_reg;
        val_next    = val_reg;
        pos_next    = pos_reg;
        strobe_next = 1'b0;
        status_next = status_reg;
        evalue_next = evalue_reg;
        last_next   = last_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[IW-1:0];
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = idx_reg[IW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_type;
                    val_next   = value;
                    pos_next   = position;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                evalue_next = '0;
                last_next   = 1'b1;
                status_next = ST_OK;
                priority if (req_reg == REQ_INS_FRONT || req_reg == REQ_INS_REAR
                             || req_reg == REQ_INS_AT)
                begin
                    priority if (count_reg == CW'(DEPTH))
                    begin
                        status_next = ST_FULL;
                        strobe_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (pos_eff > cnt_ext)
                    begin
                        status_next = ST_RANGE;
                        strobe_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        tgt_next   = CW'(pos_eff);
                        idx_next   = count_reg;
                        state_next = (cnt_ext > pos_eff) ? S_UP_RD : S_INS_WR;
                    end
                end
                else if (req_reg == REQ_DEL_FRONT || req_reg == REQ_DEL_REAR
                         || req_reg == REQ_DEL_AT)
                begin
                    priority if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        strobe_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (pos_eff >= cnt_ext)
                    begin
                        status_next = ST_RANGE;
                        strobe_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (pos_eff + CMPW'(1) < cnt_ext)
                    begin
                        idx_next   = CW'(pos_eff);
                        state_next = S_DN_RD;
                    end
                    else
                    begin
                        count_next  = count_reg - CW'(1);
                        strobe_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (req_reg == REQ_READ_ALL)
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        strobe_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        idx_next   = CW'(1);
                        state_next = S_RO;
                    end
                end
                else
                begin
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_UP_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_m1[IW-1:0];
                state_next = S_UP_WR;
            end

            S_UP_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[IW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_m1;
                state_next = (idx_m1 > tgt_reg) ? S_UP_RD : S_INS_WR;
            end

            S_INS_WR:
            begin
                ram_we      = 1'b1;
                ram_waddr   = tgt_reg[IW-1:0];
                ram_wdata   = val_reg;
                count_next  = count_reg + CW'(1);
                status_next = ST_OK;
                evalue_next = '0;
                last_next   = 1'b1;
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end

            S_DN_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_p1[IW-1:0];
                state_next = S_DN_WR;
            end

            S_DN_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[IW-1:0];
                ram_wdata = ram_rdata;
                idx_next  = idx_p1[CW-1:0];
                if (idx_p2 < {1'b0, count_reg})
                begin
                    state_next = S_DN_RD;
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = ST_OK;
                    evalue_next = '0;
                    last_next   = 1'b1;
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_RO:
            begin
                status_next = ST_OK;
                evalue_next = ram_rdata;
                strobe_next = 1'b1;
                if (idx_reg == count_reg)
                begin
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    last_next  = 1'b0;
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg[IW-1:0];
                    idx_next   = idx_p1[CW-1:0];
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        tgt_reg    <= tgt_next;
        req_reg    <= req_next;
        val_reg    <= val_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        evalue_reg <= evalue_next;
        last_reg   <= last_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign entry_value = evalue_reg;
    assign last        = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg != S_IDLE))
        else $error("result issued without a transaction in progress");

    a_error_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && status_reg != ST_OK) |-> (count_reg == $past(count_reg)))
        else $error("failed request changed the entry count");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !last_reg) |-> busy)
        else $error("read-out ended without last");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

endmodule

`default_nettype wire
